/* rtl/core/nmea_gga_position_parser_macros.svh */
// Assertion helpers for the file that carries concurrent checks.
`ifndef NMEA_GGA_POSITION_PARSER_MACROS_SVH
`define NMEA_GGA_POSITION_PARSER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define NGP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ngp check failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define NGP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ngp check failed: next-cycle implication");

`endif

/* rtl/core/ngp_pkg.sv */
`default_nettype none

package ngp_pkg;

    // Field widths
    localparam int CHAR_W  = 8;
    localparam int WHOLE_W = 17;
    localparam int ND_W    = 3;
    localparam int CNT_W   = 4;
    localparam int LAT_W   = 30;
    localparam int LON_W   = 34;
    localparam int E7_W    = 34;
    localparam int DEG_W   = 10;
    localparam int MIN_W   = 7;
    localparam int FNORM_W = 24;
    localparam int NUM_W   = 30;
    localparam int QUOT_W  = 25;

    // Number of registered stages between the closing byte and the result port
    localparam int NSTAGE = 8;

    localparam int DEF_MAX_FRAC_DIGITS = 5;
    localparam int E7_DIGITS           = 7;

    // Characters
    localparam logic [CHAR_W-1:0] CH_DOLLAR = 8'h24;
    localparam logic [CHAR_W-1:0] CH_STAR   = 8'h2A;
    localparam logic [CHAR_W-1:0] CH_COMMA  = 8'h2C;
    localparam logic [CHAR_W-1:0] CH_DOT    = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE   = 8'h39;
    localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
    localparam logic [CHAR_W-1:0] CH_DEL    = 8'h7F;

    // Field numbers after the k-th comma
    localparam logic [CNT_W-1:0] FLD_LAT   = 4'd2;
    localparam logic [CNT_W-1:0] FLD_NS    = 4'd3;
    localparam logic [CNT_W-1:0] FLD_LON   = 4'd4;
    localparam logic [CNT_W-1:0] FLD_EW    = 4'd5;
    localparam logic [CNT_W-1:0] FLD_FIX   = 4'd6;
    localparam logic [CNT_W-1:0] FLD_SATS  = 4'd7;
    localparam logic [CNT_W-1:0] COMMA_MAX = 4'd15;

    localparam logic [7:0] FIX_GPS = 8'd1;

    // Saturation limits
    localparam logic [19:0]       WHOLE_MAX = 20'd99999;
    localparam logic [19:0]       COUNT_MAX = 20'd255;
    localparam logic [E7_W-1:0]   LAT_MAX   = 34'd1006666665;
    localparam logic [E7_W-1:0]   LON_MAX   = 34'd9996666665;
    localparam logic [E7_W-1:0]   E7        = 34'd10000000;

    // Division by 100 of a 17-bit value: (w * R100) >> 24
    localparam logic [17:0] R100      = 18'd167773;
    localparam int          R100_SH   = 24;
    localparam logic [WHOLE_W-1:0] CENT = 17'd100;
    // Division by 15 of a 28-bit value: (n * R15) >> 32
    localparam logic [28:0] R15       = 29'd286331154;
    localparam int          R15_SH    = 32;

    typedef struct packed {
        logic              fix_valid;
        logic [CHAR_W-1:0] ns;
        logic [CHAR_W-1:0] ew;
        logic [7:0]        fix;
        logic [7:0]        sats;
        logic              err;
    } ngp_side_t;

    function automatic logic [FNORM_W-1:0] ngp_pow10(input logic [ND_W-1:0] n);
        logic [FNORM_W-1:0] p;
        case (n)
            3'd0: p = 24'd1;
            3'd1: p = 24'd10;
            3'd2: p = 24'd100;
            3'd3: p = 24'd1000;
            3'd4: p = 24'd10000;
            3'd5: p = 24'd100000;
            3'd6: p = 24'd1000000;
            default: p = 24'd10000000;
        endcase
        return p;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/ngp_if.sv */
`default_nettype none

interface ngp_char_if import ngp_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_in;

    modport source (output valid, output char_in, input ready);
    modport sink   (input valid, input char_in, output ready);
endinterface

interface ngp_result_if import ngp_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              fix_valid;
    logic [LAT_W-1:0]  latitude_e7;
    logic [CHAR_W-1:0] north_south_char;
    logic [LON_W-1:0]  longitude_e7;
    logic [CHAR_W-1:0] east_west_char;
    logic [7:0]        fix_quality;
    logic [7:0]        satellites;
    logic              format_error;

    modport source (output valid, output fix_valid, output latitude_e7,
                    output north_south_char, output longitude_e7,
                    output east_west_char, output fix_quality,
                    output satellites, output format_error, input ready);
    modport sink   (input valid, input fix_valid, input latitude_e7,
                    input north_south_char, input longitude_e7,
                    input east_west_char, input fix_quality,
                    input satellites, input format_error, output ready);
endinterface

`default_nettype wire

/* rtl/core/ngp_parser.sv */
`default_nettype none

module ngp_parser import ngp_pkg::*; #(
    parameter int MAX_FRAC_DIGITS = DEF_MAX_FRAC_DIGITS,
    localparam int FRAC_W = $clog2(int'(ngp_pow10(ND_W'(MAX_FRAC_DIGITS))))
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               accept,
    input  wire logic [CHAR_W-1:0]  char_in,
    output logic                    rec_valid,
    output logic [WHOLE_W-1:0]      lat_whole,
    output logic [FRAC_W-1:0]       lat_frac,
    output logic [ND_W-1:0]         lat_nd,
    output logic [WHOLE_W-1:0]      lon_whole,
    output logic [FRAC_W-1:0]       lon_frac,
    output logic [ND_W-1:0]         lon_nd,
    output ngp_side_t               rec_side
);

    logic               in_sentence_reg, in_sentence_next;
    logic [CNT_W-1:0]   comma_count_reg, comma_count_next;
    logic [WHOLE_W-1:0] whole_accum_reg, whole_accum_next;
    logic [FRAC_W-1:0]  frac_accum_reg, frac_accum_next;
    logic [ND_W-1:0]    frac_digits_reg, frac_digits_next;
    logic               seen_dot_reg, seen_dot_next;
    logic               field_seen_reg, field_seen_next;
    logic [WHOLE_W-1:0] lat_whole_reg, lat_whole_next;
    logic [FRAC_W-1:0]  lat_frac_reg, lat_frac_next;
    logic [ND_W-1:0]    lat_nd_reg, lat_nd_next;
    logic [WHOLE_W-1:0] lon_whole_reg, lon_whole_next;
    logic [FRAC_W-1:0]  lon_frac_reg, lon_frac_next;
    logic [ND_W-1:0]    lon_nd_reg, lon_nd_next;
    logic [CHAR_W-1:0]  ns_hold_reg, ns_hold_next;
    logic [CHAR_W-1:0]  ew_hold_reg, ew_hold_next;
    logic [7:0]         fix_hold_reg, fix_hold_next;
    logic [7:0]         sats_hold_reg, sats_hold_next;
    logic               error_hold_reg, error_hold_next;

    logic               is_digit, is_close, is_comma, is_dollar;
    logic [3:0]         digit_val;
    logic [19:0]        whole_x10;
    logic [FRAC_W+3:0]  frac_x10;
    logic [7:0]         whole_sat8;
    logic               fin_err;
    logic               close_err;
    logic [WHOLE_W-1:0] lat_whole_fin, lon_whole_fin;
    logic [FRAC_W-1:0]  lat_frac_fin, lon_frac_fin;
    logic [ND_W-1:0]    lat_nd_fin, lon_nd_fin;
    logic [7:0]         fix_fin, sats_fin;

    always_comb
    begin
        is_digit  = (char_in >= CH_ZERO) && (char_in <= CH_NINE);
        is_close  = (char_in == CH_STAR) || (char_in < CH_SPACE) || (char_in == CH_DEL);
        is_comma  = (char_in == CH_COMMA);
        is_dollar = (char_in == CH_DOLLAR);
        digit_val = 4'(char_in - CH_ZERO);
        whole_x10 = 20'(whole_accum_reg) * 20'd10 + 20'(digit_val);
        frac_x10  = (FRAC_W+4)'(frac_accum_reg) * (FRAC_W+4)'(10) + (FRAC_W+4)'(digit_val);
        whole_sat8 = (20'(whole_accum_reg) > COUNT_MAX) ? 8'hFF : whole_accum_reg[7:0];

        // Values as they stand once the current field has been closed.
        fin_err = (comma_count_reg >= FLD_LAT) && (comma_count_reg <= FLD_SATS)
                  && !field_seen_reg;
        lat_whole_fin = lat_whole_reg;
        lat_frac_fin  = lat_frac_reg;
        lat_nd_fin    = lat_nd_reg;
        lon_whole_fin = lon_whole_reg;
        lon_frac_fin  = lon_frac_reg;
        lon_nd_fin    = lon_nd_reg;
        fix_fin       = fix_hold_reg;
        sats_fin      = sats_hold_reg;
        if ((comma_count_reg == FLD_LAT) && field_seen_reg)
        begin
            lat_whole_fin = whole_accum_reg;
            lat_frac_fin  = frac_accum_reg;
            lat_nd_fin    = frac_digits_reg;
        end
        if ((comma_count_reg == FLD_LON) && field_seen_reg)
        begin
            lon_whole_fin = whole_accum_reg;
            lon_frac_fin  = frac_accum_reg;
            lon_nd_fin    = frac_digits_reg;
        end
        if (comma_count_reg == FLD_FIX)
            fix_fin = whole_sat8;
        if (comma_count_reg == FLD_SATS)
            sats_fin = whole_sat8;

        close_err = error_hold_reg || fin_err || (comma_count_reg < FLD_SATS);

        rec_valid = accept && !is_dollar && in_sentence_reg && is_close;
        lat_whole = lat_whole_fin;
        lat_frac  = lat_frac_fin;
        lat_nd    = lat_nd_fin;
        lon_whole = lon_whole_fin;
        lon_frac  = lon_frac_fin;
        lon_nd    = lon_nd_fin;
        rec_side.fix_valid = (fix_fin == FIX_GPS) && !close_err;
        rec_side.ns   = ns_hold_reg;
        rec_side.ew   = ew_hold_reg;
        rec_side.fix  = fix_fin;
        rec_side.sats = sats_fin;
        rec_side.err  = close_err;

        in_sentence_next = in_sentence_reg;
        comma_count_next = comma_count_reg;
        whole_accum_next = whole_accum_reg;
        frac_accum_next  = frac_accum_reg;
        frac_digits_next = frac_digits_reg;
        seen_dot_next    = seen_dot_reg;
        field_seen_next  = field_seen_reg;
        lat_whole_next   = lat_whole_reg;
        lat_frac_next    = lat_frac_reg;
        lat_nd_next      = lat_nd_reg;
        lon_whole_next   = lon_whole_reg;
        lon_frac_next    = lon_frac_reg;
        lon_nd_next      = lon_nd_reg;
        ns_hold_next     = ns_hold_reg;
        ew_hold_next     = ew_hold_reg;
        fix_hold_next    = fix_hold_reg;
        sats_hold_next   = sats_hold_reg;
        error_hold_next  = error_hold_reg;

        if (accept)
        begin
            if (is_dollar)
            begin
                in_sentence_next = 1'b1;
                comma_count_next = '0;
                whole_accum_next = '0;
                frac_accum_next  = '0;
                frac_digits_next = '0;
                seen_dot_next    = 1'b0;
                field_seen_next  = 1'b0;
                lat_whole_next   = '0;
                lat_frac_next    = '0;
                lat_nd_next      = '0;
                lon_whole_next   = '0;
                lon_frac_next    = '0;
                lon_nd_next      = '0;
                ns_hold_next     = '0;
                ew_hold_next     = '0;
                fix_hold_next    = '0;
                sats_hold_next   = '0;
                error_hold_next  = 1'b0;
            end
            else if (in_sentence_reg)
            begin
                if (is_close)
                begin
                    // The result item carries everything; the next '$' clears the rest.
                    in_sentence_next = 1'b0;
                end
                else if (is_comma)
                begin
                    error_hold_next  = error_hold_reg || fin_err;
                    lat_whole_next   = lat_whole_fin;
                    lat_frac_next    = lat_frac_fin;
                    lat_nd_next      = lat_nd_fin;
                    lon_whole_next   = lon_whole_fin;
                    lon_frac_next    = lon_frac_fin;
                    lon_nd_next      = lon_nd_fin;
                    fix_hold_next    = fix_fin;
                    sats_hold_next   = sats_fin;
                    whole_accum_next = '0;
                    frac_accum_next  = '0;
                    frac_digits_next = '0;
                    seen_dot_next    = 1'b0;
                    field_seen_next  = 1'b0;
                    if (comma_count_reg != COMMA_MAX)
                        comma_count_next = comma_count_reg + 4'd1;
                end
                else
                begin
                    case (comma_count_reg) inside
                        FLD_LAT, FLD_LON:
                        begin
                            if (is_digit)
                            begin
                                field_seen_next = 1'b1;
                                if (seen_dot_reg)
                                begin
                                    if (frac_digits_reg < ND_W'(MAX_FRAC_DIGITS))
                                    begin
                                        frac_accum_next  = FRAC_W'(frac_x10);
                                        frac_digits_next = frac_digits_reg + 3'd1;
                                    end
                                end
                                else if (whole_x10 > WHOLE_MAX)
                                    whole_accum_next = WHOLE_W'(WHOLE_MAX);
                                else
                                    whole_accum_next = WHOLE_W'(whole_x10);
                            end
                            else if ((char_in == CH_DOT) && !seen_dot_reg)
                                seen_dot_next = 1'b1;
                            else
                                error_hold_next = 1'b1;
                        end
                        FLD_NS, FLD_EW:
                        begin
                            if (!field_seen_reg)
                            begin
                                if (comma_count_reg == FLD_NS)
                                    ns_hold_next = char_in;
                                else
                                    ew_hold_next = char_in;
                            end
                            field_seen_next = 1'b1;
                        end
                        FLD_FIX, FLD_SATS:
                        begin
                            if (is_digit)
                            begin
                                field_seen_next = 1'b1;
                                if (whole_x10 > COUNT_MAX)
                                    whole_accum_next = WHOLE_W'(COUNT_MAX);
                                else
                                    whole_accum_next = WHOLE_W'(whole_x10);
                            end
                            else
                                error_hold_next = 1'b1;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_sentence_reg <= 1'b0;
            comma_count_reg <= '0;
            whole_accum_reg <= '0;
            frac_accum_reg  <= '0;
            frac_digits_reg <= '0;
            seen_dot_reg    <= 1'b0;
            field_seen_reg  <= 1'b0;
            lat_whole_reg   <= '0;
            lat_frac_reg    <= '0;
            lat_nd_reg      <= '0;
            lon_whole_reg   <= '0;
            lon_frac_reg    <= '0;
            lon_nd_reg      <= '0;
            ns_hold_reg     <= '0;
            ew_hold_reg     <= '0;
            fix_hold_reg    <= '0;
            sats_hold_reg   <= '0;
            error_hold_reg  <= 1'b0;
        end
        else
        begin
            in_sentence_reg <= in_sentence_next;
            comma_count_reg <= comma_count_next;
            whole_accum_reg <= whole_accum_next;
            frac_accum_reg  <= frac_accum_next;
            frac_digits_reg <= frac_digits_next;
            seen_dot_reg    <= seen_dot_next;
            field_seen_reg  <= field_seen_next;
            lat_whole_reg   <= lat_whole_next;
            lat_frac_reg    <= lat_frac_next;
            lat_nd_reg      <= lat_nd_next;
            lon_whole_reg   <= lon_whole_next;
            lon_frac_reg    <= lon_frac_next;
            lon_nd_reg      <= lon_nd_next;
            ns_hold_reg     <= ns_hold_next;
            ew_hold_reg     <= ew_hold_next;
            fix_hold_reg    <= fix_hold_next;
            sats_hold_reg   <= sats_hold_next;
            error_hold_reg  <= error_hold_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/ngp_to_e7.sv */
`default_nettype none

// Converts DDMM.mmmm (whole part, kept fraction digits and their count) into
// degrees in units of 1e-7. The fraction is first scaled to a fixed number of
// digits so that the division by sixty minutes is by a constant.
module ngp_to_e7 import ngp_pkg::*; #(
    parameter int              MAX_FRAC_DIGITS = DEF_MAX_FRAC_DIGITS,
    parameter logic [E7_W-1:0] LIMIT           = LON_MAX,
    localparam int FRAC_W = $clog2(int'(ngp_pow10(ND_W'(MAX_FRAC_DIGITS))))
) (
    input  wire logic               clk,
    input  wire logic [NSTAGE-1:0]  en,
    input  wire logic [WHOLE_W-1:0] whole,
    input  wire logic [FRAC_W-1:0]  frac,
    input  wire logic [ND_W-1:0]    nd,
    output logic      [E7_W-1:0]    e7
);

    localparam logic [NUM_W-1:0] POW_M    = NUM_W'(ngp_pow10(ND_W'(MAX_FRAC_DIGITS)));
    localparam logic [NUM_W-1:0] POW_REST =
        NUM_W'(ngp_pow10(ND_W'(E7_DIGITS - MAX_FRAC_DIGITS)));

    logic [WHOLE_W-1:0] w0_reg, w1_reg;
    logic [FRAC_W-1:0]  f0_reg;
    logic [ND_W-1:0]    n0_reg;
    logic [DEG_W-1:0]   q1_reg, q2_reg, q3_reg, q4_reg, q5_reg;
    logic [FNORM_W-1:0] fn1_reg, fn2_reg;
    logic [MIN_W-1:0]   mn2_reg;
    logic [NUM_W-1:0]   a3_reg, n4_reg;
    logic [QUOT_W-1:0]  quot5_reg, quot6_reg;
    logic [E7_W-1:0]    d6_reg, e7_reg;

    logic [34:0]        q1_prod;
    logic [FNORM_W-1:0] fn1_next;
    logic [WHOLE_W-1:0] rem2;
    logic [56:0]        quot5_prod;
    logic [E7_W-1:0]    sum7;

    always_comb
    begin
        q1_prod    = 35'(w0_reg) * 35'(R100);
        fn1_next   = FNORM_W'(f0_reg) * ngp_pow10(ND_W'(MAX_FRAC_DIGITS) - n0_reg);
        rem2       = w1_reg - WHOLE_W'(q1_reg) * CENT;
        // floor(n / 60) taken as floor(floor(n / 4) / 15)
        quot5_prod = 57'(n4_reg[NUM_W-1:2]) * 57'(R15);
        sum7       = d6_reg + E7_W'(quot6_reg);
        e7         = e7_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            w0_reg <= whole;
            f0_reg <= frac;
            n0_reg <= nd;
        end
        if (en[1])
        begin
            q1_reg  <= q1_prod[R100_SH+DEG_W-1:R100_SH];
            w1_reg  <= w0_reg;
            fn1_reg <= fn1_next;
        end
        if (en[2])
        begin
            mn2_reg <= rem2[MIN_W-1:0];
            q2_reg  <= q1_reg;
            fn2_reg <= fn1_reg;
        end
        if (en[3])
        begin
            a3_reg <= NUM_W'(mn2_reg) * POW_M + NUM_W'(fn2_reg);
            q3_reg <= q2_reg;
        end
        if (en[4])
        begin
            n4_reg <= a3_reg * POW_REST;
            q4_reg <= q3_reg;
        end
        if (en[5])
        begin
            quot5_reg <= quot5_prod[R15_SH+QUOT_W-1:R15_SH];
            q5_reg    <= q4_reg;
        end
        if (en[6])
        begin
            d6_reg    <= E7_W'(q5_reg) * E7;
            quot6_reg <= quot5_reg;
        end
        if (en[7])
            e7_reg <= (sum7 > LIMIT) ? LIMIT : sum7;
    end

endmodule

`default_nettype wire

/* rtl/core/nmea_gga_position_parser.sv */
// Channel      Direction  Payload
// char_chan    in         char_in (8)
// result_chan  out        fix_valid, latitude_e7 (30), north_south_char,
//                         longitude_e7 (34), east_west_char, fix_quality,
//                         satellites, format_error
//
// One byte is accepted every cycle while char_chan.ready is high. A closing byte
// starts a result item down an eight-stage conversion pipeline, offered from its
// last stage. Each stage advances whenever the one after it is empty or moving, so
// bubbles close up behind a stalled result and char_chan.ready falls only when all
// eight stages hold items. Reset clears the parser state and the stage valid bits.
`default_nettype none

`include "nmea_gga_position_parser_macros.svh"

module nmea_gga_position_parser import ngp_pkg::*; #(
    parameter int MAX_FRAC_DIGITS = DEF_MAX_FRAC_DIGITS
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    ngp_char_if.sink   char_chan,
    ngp_result_if.source result_chan
);

    localparam int FRAC_W = $clog2(int'(ngp_pow10(ND_W'(MAX_FRAC_DIGITS))));

    logic               accept;
    logic               rec_valid;
    logic [WHOLE_W-1:0] lat_whole, lon_whole;
    logic [FRAC_W-1:0]  lat_frac, lon_frac;
    logic [ND_W-1:0]    lat_nd, lon_nd;
    ngp_side_t          rec_side;
    logic [E7_W-1:0]    lat_e7, lon_e7;

    logic [NSTAGE:0]    stage_ready;
    logic [NSTAGE-1:0]  stage_valid_reg, stage_valid_next;
    ngp_side_t          side_reg [NSTAGE];

    always_comb
    begin
        stage_ready[NSTAGE] = result_chan.ready;
        for (int i = NSTAGE - 1; i >= 0; i--)
            stage_ready[i] = !stage_valid_reg[i] || stage_ready[i+1];
        for (int i = 0; i < NSTAGE; i++)
        begin
            if (!stage_ready[i])
                stage_valid_next[i] = stage_valid_reg[i];
            else if (i == 0)
                stage_valid_next[i] = rec_valid;
            else
                stage_valid_next[i] = stage_valid_reg[i-1];
        end
    end

    assign char_chan.ready = stage_ready[0];
    assign accept          = char_chan.valid && stage_ready[0];

    ngp_parser #(
        .MAX_FRAC_DIGITS (MAX_FRAC_DIGITS)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .char_in   (char_chan.char_in),
        .rec_valid (rec_valid),
        .lat_whole (lat_whole),
        .lat_frac  (lat_frac),
        .lat_nd    (lat_nd),
        .lon_whole (lon_whole),
        .lon_frac  (lon_frac),
        .lon_nd    (lon_nd),
        .rec_side  (rec_side)
    );

    ngp_to_e7 #(
        .MAX_FRAC_DIGITS (MAX_FRAC_DIGITS),
        .LIMIT           (LAT_MAX)
    ) u_lat (
        .clk   (clk),
        .en    (stage_ready[NSTAGE-1:0]),
        .whole (lat_whole),
        .frac  (lat_frac),
        .nd    (lat_nd),
        .e7    (lat_e7)
    );

    ngp_to_e7 #(
        .MAX_FRAC_DIGITS (MAX_FRAC_DIGITS),
        .LIMIT           (LON_MAX)
    ) u_lon (
        .clk   (clk),
        .en    (stage_ready[NSTAGE-1:0]),
        .whole (lon_whole),
        .frac  (lon_frac),
        .nd    (lon_nd),
        .e7    (lon_e7)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stage_valid_reg <= '0;
        else
            stage_valid_reg <= stage_valid_next;
    end

    // The remaining result fields ride alongside the conversion stages.
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NSTAGE; i++)
        begin
            if (stage_ready[i])
            begin
                if (i == 0)
                    side_reg[i] <= rec_side;
                else
                    side_reg[i] <= side_reg[i-1];
            end
        end
    end

    assign result_chan.valid            = stage_valid_reg[NSTAGE-1];
    assign result_chan.fix_valid        = side_reg[NSTAGE-1].fix_valid;
    assign result_chan.latitude_e7      = lat_e7[LAT_W-1:0];
    assign result_chan.north_south_char = side_reg[NSTAGE-1].ns;
    assign result_chan.longitude_e7     = lon_e7[LON_W-1:0];
    assign result_chan.east_west_char   = side_reg[NSTAGE-1].ew;
    assign result_chan.fix_quality      = side_reg[NSTAGE-1].fix;
    assign result_chan.satellites       = side_reg[NSTAGE-1].sats;
    assign result_chan.format_error     = side_reg[NSTAGE-1].err;

    `NGP_ASSERT_IMP(a_ready_only_when_full, clk, rst_n, !char_chan.ready, &stage_valid_reg)
    `NGP_ASSERT_NEXT(a_close_enters_pipe, clk, rst_n, rec_valid, stage_valid_reg[0])
    `NGP_ASSERT_IMP(a_lat_in_range, clk, rst_n, result_chan.valid,
                    E7_W'(result_chan.latitude_e7) <= LAT_MAX)
    `NGP_ASSERT_IMP(a_fix_consistent, clk, rst_n, result_chan.valid && result_chan.fix_valid,
                    !result_chan.format_error && (result_chan.fix_quality == FIX_GPS))

endmodule

`default_nettype wire

/* sim/testbench.sv */
`default_nettype none

module testbench;
    import ngp_pkg::*;

    typedef struct packed {
        logic              fix_valid;
        logic [LAT_W-1:0]  latitude_e7;
        logic [CHAR_W-1:0] north_south_char;
        logic [LON_W-1:0]  longitude_e7;
        logic [CHAR_W-1:0] east_west_char;
        logic [7:0]        fix_quality;
        logic [7:0]        satellites;
        logic              format_error;
    } gga_fix_t;

    function automatic string fix_text(gga_fix_t f);
        return $sformatf("fix=%0d lat=%0d ns=%02h lon=%0d ew=%02h q=%0d sats=%0d err=%0d",
                         f.fix_valid, f.latitude_e7, f.north_south_char, f.longitude_e7,
                         f.east_west_char, f.fix_quality, f.satellites, f.format_error);
    endfunction

    // Tracks the parser byte by byte and holds the fixes it should report.
    class gga_scoreboard;
        bit                in_gga;
        bit [CNT_W-1:0]    commas;
        bit [WHOLE_W-1:0]  whole;
        bit [WHOLE_W-1:0]  frac;
        bit [ND_W-1:0]     nfrac;
        bit                dot_seen;
        bit                got_any;
        bit [LAT_W-1:0]    lat;
        bit [LON_W-1:0]    lon;
        bit [7:0]          ns;
        bit [7:0]          ew;
        bit [7:0]          fixq;
        bit [7:0]          nsat;
        bit                err;
        gga_fix_t          pending_fixes[$];
        int                mismatches;
        int                checked;
        int                good_fixes;
        int                flagged;

        function void clear_field();
            whole = 0;
            frac = 0;
            nfrac = 0;
            dot_seen = 0;
            got_any = 0;
        endfunction

        function void clear_sentence();
            commas = 0;
            clear_field();
            lat = 0;
            lon = 0;
            ns = 0;
            ew = 0;
            fixq = 0;
            nsat = 0;
            err = 0;
        endfunction

        // Whole degrees plus minutes over sixty, truncated, in units of 1e-7 degree.
        function longint unsigned degrees_e7(longint unsigned ceiling);
            longint unsigned w;
            longint unsigned scale;
            longint unsigned r;
            w = 64'(whole);
            scale = 1;
            for (int i = 0; i < nfrac; i++)
                scale = scale * 10;
            r = (w / 100) * 64'd10000000
                + (((w % 100) * scale + frac) * 64'd10000000) / (60 * scale);
            return (r > ceiling) ? ceiling : r;
        endfunction

        function void close_field();
            if (commas >= FLD_LAT && commas <= FLD_SATS && !got_any)
                err = 1;
            if (commas == FLD_LAT && got_any)
                lat = LAT_W'(degrees_e7(64'(LAT_MAX)));
            else if (commas == FLD_LON && got_any)
                lon = LON_W'(degrees_e7(64'(LON_MAX)));
            else if (commas == FLD_FIX)
                fixq = (whole > 255) ? 8'd255 : whole[7:0];
            else if (commas == FLD_SATS)
                nsat = (whole > 255) ? 8'd255 : whole[7:0];
            clear_field();
        endfunction

        function void take_char(bit [7:0] c);
            bit          digit;
            int unsigned acc;
            gga_fix_t    want;
            digit = (c >= CH_ZERO) && (c <= CH_NINE);
            if (c == CH_DOLLAR) begin
                in_gga = 1;
                clear_sentence();
                return;
            end
            if (!in_gga)
                return;
            if (c == CH_STAR || c < CH_SPACE || c == CH_DEL) begin
                close_field();
                if (commas < FLD_SATS)
                    err = 1;
                in_gga = 0;
                want.fix_valid        = (fixq == FIX_GPS) && !err;
                want.latitude_e7      = lat;
                want.north_south_char = ns;
                want.longitude_e7     = lon;
                want.east_west_char   = ew;
                want.fix_quality      = fixq;
                want.satellites       = nsat;
                want.format_error     = err;
                pending_fixes.push_back(want);
                good_fixes += want.fix_valid;
                flagged += want.format_error;
                return;
            end
            if (c == CH_COMMA) begin
                close_field();
                if (commas != COMMA_MAX)
                    commas++;
                return;
            end
            case (commas)
                FLD_LAT, FLD_LON:
                begin
                    if (digit) begin
                        got_any = 1;
                        if (dot_seen) begin
                            if (nfrac < DEF_MAX_FRAC_DIGITS) begin
                                frac = WHOLE_W'(frac * 10 + (c - CH_ZERO));
                                nfrac++;
                            end
                        end
                        else begin
                            acc = whole * 10 + (c - CH_ZERO);
                            whole = WHOLE_W'((acc > WHOLE_MAX) ? WHOLE_MAX : acc);
                        end
                    end
                    else if (c == CH_DOT && !dot_seen)
                        dot_seen = 1;
                    else
                        err = 1;
                end
                FLD_NS:
                begin
                    if (!got_any)
                        ns = c;
                    got_any = 1;
                end
                FLD_EW:
                begin
                    if (!got_any)
                        ew = c;
                    got_any = 1;
                end
                FLD_FIX, FLD_SATS:
                begin
                    if (digit) begin
                        got_any = 1;
                        acc = whole * 10 + (c - CH_ZERO);
                        whole = WHOLE_W'((acc > 255) ? 255 : acc);
                    end
                    else
                        err = 1;
                end
                default: ;
            endcase
        endfunction

        function void check_fix(gga_fix_t got);
            gga_fix_t want;
            if (pending_fixes.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result with nothing expected: %s", $realtime, fix_text(got));
                return;
            end
            want = pending_fixes.pop_front();
            checked++;
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("%0t: mismatch", $realtime);
                    $display("    expected %s", fix_text(want));
                    $display("    actual   %s", fix_text(got));
                end
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    ngp_char_if   char_chan ();
    ngp_result_if result_chan ();

    nmea_gga_position_parser u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .char_chan   (char_chan),
        .result_chan (result_chan)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    gga_scoreboard sb;
    logic [7:0]    tx_q[$];
    bit            steady;
    int            sent;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic void put(logic [7:0] b);
        tx_q.push_back(b);
    endfunction

    function automatic void put_str(string s);
        for (int i = 0; i < s.len(); i++)
            put(s[i]);
    endfunction

    function automatic void put_number(int unsigned v);
        put_str($sformatf("%0d", v));
    endfunction

    function automatic void put_digits(int n);
        for (int i = 0; i < n; i++)
            put(8'(CH_ZERO + $urandom_range(0, 9)));
    endfunction

    function automatic void put_position(int whole_digits);
        int nd;
        nd = ($urandom_range(0, 9) < 7) ? whole_digits : $urandom_range(0, 7);
        put_digits(nd);
        if ($urandom_range(0, 9) != 0) begin
            put(CH_DOT);
            put_digits(($urandom_range(0, 3) == 0) ? $urandom_range(0, 8) : $urandom_range(3, 5));
        end
        // Now and then a second dot or another printable non-digit byte.
        if ($urandom_range(0, 24) == 0)
            put($urandom_range(0, 1) ? CH_DOT : 8'($urandom_range(8'h3A, 8'h7E)));
    endfunction

    function automatic void put_hemisphere(logic [7:0] a, logic [7:0] b);
        int r;
        r = $urandom_range(0, 19);
        if (r < 16)
            put($urandom_range(0, 1) ? a : b);
        else if (r == 17) begin
            put(a);
            put(b);
        end
        else if (r == 18)
            put(8'($urandom_range(8'h80, 8'hFF)));
        else if (r == 19)
            put_str("Xyz");
    endfunction

    function automatic void put_random_sentence();
        int last;
        int r;
        put(CH_DOLLAR);
        put_str($urandom_range(0, 1) ? "GPGGA" : "GNGGA");
        last = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 18) : 14;
        for (int f = 1; f <= last; f++) begin
            put(CH_COMMA);
            r = $urandom_range(0, 19);
            case (f)
                1:
                begin
                    put_digits(6);
                    put(CH_DOT);
                    put_digits(2);
                end
                2: put_position(4);
                3: put_hemisphere("N", "S");
                4: put_position(5);
                5: put_hemisphere("E", "W");
                6:
                begin
                    if (r < 14)
                        put("1");
                    else if (r < 18)
                        put_number($urandom_range(0, 8));
                    else if (r == 18)
                        put_number($urandom_range(0, 999));
                end
                7:
                begin
                    if (r < 16)
                        put_str($sformatf("%02d", $urandom_range(0, 24)));
                    else if (r < 18)
                        put_number($urandom_range(0, 9999));
                end
                default:
                begin
                    put_digits($urandom_range(0, 3));
                    if (r < 5)
                        put_str(".M");
                end
            endcase
            // A stray byte of any value goes in after a field now and then.
            if ($urandom_range(0, 39) == 0)
                put(8'($urandom_range(0, 255)));
        end
        r = $urandom_range(0, 19);
        if (r < 14) begin
            put(CH_STAR);
            put_str($sformatf("%02X", $urandom_range(0, 255)));
            put(8'h0D);
            put(8'h0A);
        end
        else if (r < 17) begin
            put(8'h0D);
            put(8'h0A);
        end
        else if (r < 19)
            put(8'($urandom_range(0, 31)));
        else
            put(CH_DEL);
    endfunction

    task automatic send_char(logic [7:0] c);
        int gap;
        bit taken;
        gap = steady ? 0 : pick_gap();
        if (gap > 0) begin
            char_chan.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        char_chan.valid   <= 1'b1;
        char_chan.char_in <= c;
        do
        begin
            @(negedge clk);
            taken = char_chan.ready;
            @(posedge clk);
        end
        while (!taken);
        sent++;
    endtask

    task automatic send_pending();
        steady = ($urandom_range(0, 4) == 0);
        while (tx_q.size() != 0)
            send_char(tx_q.pop_front());
    endtask

    task automatic hold_until_empty();
        char_chan.valid <= 1'b0;
        while (sb.pending_fixes.size() != 0)
            @(posedge clk);
    endtask

    // Receiver: alternating ready and stall spans, with the odd long open stretch.
    initial
    begin
        int span;
        bit level;
        result_chan.ready <= 1'b0;
        level = 1'b0;
        span = 0;
        forever
        begin
            @(posedge clk);
            if (span == 0) begin
                level = !level;
                if (level)
                    span = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                       : $urandom_range(1, 12);
                else
                    span = pick_gap();
                if (span == 0) begin
                    level = 1'b1;
                    span = $urandom_range(1, 12);
                end
            end
            result_chan.ready <= level;
            span--;
        end
    end

    // Sampling at the falling edge sees the values that the next rising edge accepts.
    always @(negedge clk)
    begin
        gga_fix_t got;
        if (rst_n === 1'b1) begin
            if (char_chan.valid && char_chan.ready)
                sb.take_char(char_chan.char_in);
            if (result_chan.valid && result_chan.ready) begin
                got.fix_valid        = result_chan.fix_valid;
                got.latitude_e7      = result_chan.latitude_e7;
                got.north_south_char = result_chan.north_south_char;
                got.longitude_e7     = result_chan.longitude_e7;
                got.east_west_char   = result_chan.east_west_char;
                got.fix_quality      = result_chan.fix_quality;
                got.satellites       = result_chan.satellites;
                got.format_error     = result_chan.format_error;
                sb.check_fix(got);
            end
        end
    end

    initial
    begin
        #12000000;
        $display("timeout with %0d results outstanding", sb.pending_fixes.size());
        $display("testbench failed");
        $finish;
    end

    initial
    begin
        int  guard;
        bit  paused;
        sb = new();
        sent = 0;
        paused = 0;
        steady = 0;
        rst_n <= 1'b0;
        char_chan.valid   <= 1'b0;
        char_chan.char_in <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        put_str("$GPGGA,123519,4807.038,N,01131.000,E,1,08,0.9,545.4,M,46.9,M,,*47");
        put(8'h0D);
        put(8'h0A);
        // Positions near the largest real latitude and longitude, and the smallest ones.
        put_str("$GPGGA,0,8959.99999,S,17959.99999,W,1,99*");
        put_str("$GPGGA,0,0000.00000,N,00000.00000,E,1,0*");
        // Whole parts beyond five digits saturate, and so do both positions.
        put_str("$GPGGA,0,99999999.9,N,99999.99999,E,9,12*");
        // Fraction digits after the fifth are dropped.
        put_str("$GPGGA,0,4807.0381234,N,01131.9999999,E,1,07*");
        put_str("$GPGGA,,,,,,,*");
        // Closed by a delete byte before the fix and satellite fields.
        put_str("$GPGGA,1,4807.038,N,01131.000");
        put(CH_DEL);
        // A lone dot counts as a missing position; a leading dot does not.
        put_str("$GPGGA,,.,N,.5,E,1,5*");
        put_str("$GPGGA,,48a7.0,N,011.31.0,E,1x,-3*");
        // Long hemisphere fields, a high-bit hemisphere byte, oversized counts.
        put_str("$GPGGA,,1234.5,North,01234.5,EW,300,999*");
        put_str("$GPGGA,,1234.5,");
        put(8'hFF);
        put_str(",01234.5,W,0,1234*");
        put_str("$GPGGA,12,48$GPGGA,,1234.5,N,01234.5,E,2,12*");
        // Outside a sentence even closing bytes are ignored.
        put_str("junk*,9");
        put(8'h00);
        put(8'h0D);
        put_str("$GPGGA,,0100.0,N,00100.0,E,1,4,,,,,,,,,,,,,");
        put(8'h00);
        put_str("$GPGGA,,0030,S,00030,W,001,0");
        put(8'h0A);
        send_pending();
        hold_until_empty();

        while (sent < 1400)
        begin
            if ($urandom_range(0, 5) == 0)
                repeat ($urandom_range(1, 8)) put(8'($urandom_range(0, 255)));
            put_random_sentence();
            send_pending();
            if (!paused && sent > 700) begin
                hold_until_empty();
                paused = 1;
            end
        end
        char_chan.valid <= 1'b0;

        guard = 0;
        while (sb.pending_fixes.size() != 0 && guard < 100000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (20) @(posedge clk);
        if (sb.pending_fixes.size() != 0) begin
            $display("%0d expected results never arrived", sb.pending_fixes.size());
            sb.mismatches += sb.pending_fixes.size();
        end

        $display("%0d bytes sent; %0d sentence results checked, %0d with a usable fix, %0d flagged",
                 sent, sb.checked, sb.good_fixes, sb.flagged);
        $display("%0d mismatches; both sides idled at random, with one full drain midway",
                 sb.mismatches);
        if (sb.mismatches == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule

`default_nettype wire
